FILE: hdl/bpvc_pkg.sv
// Shared types and constants for the base proportional velocity controller.
// No dependencies; used by bpvc_scale_clamp and the top level.
package bpvc_pkg;

  // Field widths
  localparam int OFFSET_W     = 32;
  localparam int YAW_W        = 19;
  localparam int VEL_W        = 32;
  localparam int GAIN_W       = 16;
  localparam int LIMIT_W      = 31;
  localparam int THR_BASE_W   = 16;
  localparam int DWELL_W      = 16;

  // Configuration port
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 31;

  // Stream word widths (padded to whole bytes)
  localparam int S_TDATA_W    = 88;
  localparam int M_TDATA_W    = 96;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_X     = 3'd0,
    CFG_GAIN_Y     = 3'd1,
    CFG_GAIN_YAW   = 3'd2,
    CFG_MAX_LIN    = 3'd3,
    CFG_MAX_ANG    = 3'd4,
    CFG_DIST_THR   = 3'd5,
    CFG_YAW_THR    = 3'd6,
    CFG_DWELL      = 3'd7
  } cfg_idx_e;

  // Register reset values
  localparam logic [GAIN_W-1:0]     GAIN_RST     = 16'd128;    // 0.5 in Q8.8
  localparam logic [LIMIT_W-1:0]    MAX_LIN_RST  = 31'd16384;  // 0.25 in Q16
  localparam logic [LIMIT_W-1:0]    MAX_ANG_RST  = 31'd39322;  // 0.6 in Q16
  localparam logic [THR_BASE_W-1:0] DIST_THR_RST = 16'd164;    // 0.0025 in Q16
  localparam logic [THR_BASE_W-1:0] YAW_THR_RST  = 16'd2621;   // 0.04 in Q16
  localparam logic [DWELL_W-1:0]    DWELL_RST    = 16'd50;

endpackage

FILE: hdl/base_proportional_velocity_control_top.sv
// Proportional base velocity controller with speed saturation and a stop region.
// Result path: an accepted word goes into the input register, then into the result
// register once that register is empty or being drained.
// Throughput: one word per cycle while the master side keeps up; with m_axis_tready low
// one more word is taken into the input register, then s_axis_tready drops.
// Reset (rst_ni low, async): pipeline empty, stop tracking cleared, all registers
// back to their default gains, limits, thresholds and dwell count.
// Depends on bpvc_pkg and bpvc_scale_clamp.
module base_proportional_velocity_control_top #(
  parameter int LOW_PRECISION_MULT = 10  // threshold scale in low precision, 1..100
) (
  input  logic clk_i,
  input  logic rst_ni,

  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [bpvc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bpvc_pkg::CFG_DATA_W-1:0]   cfg_data_i,

  // input words
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // offset_x [31:0], offset_y [63:32], offset_yaw [82:64], zero pad [87:83]
  input  logic [bpvc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // precise [0]
  input  logic                              s_axis_tuser,

  // result words
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // vel_x [31:0], vel_y [63:32], vel_yaw [95:64]
  output logic [bpvc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // at_goal [0]
  output logic                              m_axis_tuser
);

  // Scaled thresholds need room for 65535 * LOW_PRECISION_MULT
  localparam int THR_W   = bpvc_pkg::THR_BASE_W + $clog2(LOW_PRECISION_MULT + 1);
  localparam int SQ_W    = 2 * bpvc_pkg::OFFSET_W;
  localparam int CMP_W   = (2 * THR_W > SQ_W) ? 2 * THR_W : SQ_W;
  localparam int YCMP_W  = (THR_W > bpvc_pkg::YAW_W) ? THR_W : bpvc_pkg::YAW_W;
  localparam int OW      = bpvc_pkg::OFFSET_W;
  localparam int YW      = bpvc_pkg::YAW_W;
  localparam int VW      = bpvc_pkg::VEL_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [bpvc_pkg::GAIN_W-1:0]     gain_x_q, gain_y_q, gain_yaw_q;
  logic [bpvc_pkg::LIMIT_W-1:0]    max_lin_q, max_ang_q;
  logic [bpvc_pkg::THR_BASE_W-1:0] dist_thr_q, yaw_thr_q;
  logic [bpvc_pkg::DWELL_W-1:0]    dwell_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_x_q   <= bpvc_pkg::GAIN_RST;
      gain_y_q   <= bpvc_pkg::GAIN_RST;
      gain_yaw_q <= bpvc_pkg::GAIN_RST;
      max_lin_q  <= bpvc_pkg::MAX_LIN_RST;
      max_ang_q  <= bpvc_pkg::MAX_ANG_RST;
      dist_thr_q <= bpvc_pkg::DIST_THR_RST;
      yaw_thr_q  <= bpvc_pkg::YAW_THR_RST;
      dwell_q    <= bpvc_pkg::DWELL_RST;
    end else if (cfg_we_i) begin
      unique case (bpvc_pkg::cfg_idx_e'(cfg_idx_i))
        bpvc_pkg::CFG_GAIN_X:   gain_x_q   <= cfg_data_i[bpvc_pkg::GAIN_W-1:0];
        bpvc_pkg::CFG_GAIN_Y:   gain_y_q   <= cfg_data_i[bpvc_pkg::GAIN_W-1:0];
        bpvc_pkg::CFG_GAIN_YAW: gain_yaw_q <= cfg_data_i[bpvc_pkg::GAIN_W-1:0];
        bpvc_pkg::CFG_MAX_LIN:  max_lin_q  <= cfg_data_i[bpvc_pkg::LIMIT_W-1:0];
        bpvc_pkg::CFG_MAX_ANG:  max_ang_q  <= cfg_data_i[bpvc_pkg::LIMIT_W-1:0];
        bpvc_pkg::CFG_DIST_THR: dist_thr_q <= cfg_data_i[bpvc_pkg::THR_BASE_W-1:0];
        bpvc_pkg::CFG_YAW_THR:  yaw_thr_q  <= cfg_data_i[bpvc_pkg::THR_BASE_W-1:0];
        bpvc_pkg::CFG_DWELL:    dwell_q    <= cfg_data_i[bpvc_pkg::DWELL_W-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake: input register, then result register.
  // Stage 1 moves on whenever the result register is empty or being drained,
  // so a new word is taken every cycle while the master side keeps up.
  // ---------------------------------------------------------------------------
  logic s1_valid_q, m_valid_q;
  logic res_free;   // result register can load this cycle
  logic s1_fire;    // word in stage 1 moves to the result register
  logic in_fire;

  assign res_free      = !m_valid_q || m_axis_tready;
  assign s1_fire       = s1_valid_q && res_free;
  assign s_axis_tready = !s1_valid_q || res_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (res_free) begin
        m_valid_q <= s1_valid_q;
      end
    end
  end

  // stage 1 payload
  logic [OW-1:0] x_q, y_q;
  logic [YW-1:0] yaw_q;
  logic          precise_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q       <= s_axis_tdata[OW-1:0];
      y_q       <= s_axis_tdata[2*OW-1:OW];
      yaw_q     <= s_axis_tdata[2*OW+YW-1:2*OW];
      precise_q <= s_axis_tuser;
    end
  end

  // ---------------------------------------------------------------------------
  // Stop region test
  // ---------------------------------------------------------------------------
  logic [OW-1:0]      ax, ay;
  logic [YW-1:0]      ayaw;
  logic [THR_W-1:0]   dthr, ythr;
  logic [2*THR_W-1:0] dthr_sq;
  logic [SQ_W-1:0]    dist_sq;
  logic               in_stop;

  // magnitudes; the most negative value maps to its unsigned magnitude
  assign ax   = x_q[OW-1]   ? (~x_q + OW'(1))   : x_q;
  assign ay   = y_q[OW-1]   ? (~y_q + OW'(1))   : y_q;
  assign ayaw = yaw_q[YW-1] ? (~yaw_q + YW'(1)) : yaw_q;

  // low precision widens both thresholds
  assign dthr = precise_q ? THR_W'(dist_thr_q)
                          : THR_W'(dist_thr_q) * THR_W'(LOW_PRECISION_MULT);
  assign ythr = precise_q ? THR_W'(yaw_thr_q)
                          : THR_W'(yaw_thr_q) * THR_W'(LOW_PRECISION_MULT);

  assign dthr_sq = (2*THR_W)'(dthr) * (2*THR_W)'(dthr);
  // magnitudes reach 2^31 at most, so the sum peaks at 2^63 and fits in 64 bits
  assign dist_sq = SQ_W'(ax) * SQ_W'(ax) + SQ_W'(ay) * SQ_W'(ay);

  assign in_stop = (CMP_W'(dist_sq) < CMP_W'(dthr_sq))
                && (YCMP_W'(ayaw) < YCMP_W'(ythr));

  // ---------------------------------------------------------------------------
  // Dwell tracking (high precision only)
  // ---------------------------------------------------------------------------
  logic                        stop_armed_q, stop_armed_d;
  logic [bpvc_pkg::DWELL_W-1:0] dwell_cnt_q, dwell_cnt_d;
  logic                        at_goal;

  always_comb begin
    stop_armed_d = stop_armed_q;
    dwell_cnt_d  = dwell_cnt_q;
    at_goal      = 1'b0;
    if (in_stop) begin
      if (!precise_q) begin
        at_goal = 1'b1;
      end else begin
        if (!stop_armed_q) begin
          stop_armed_d = 1'b1;
          dwell_cnt_d  = '0;
        end else if (dwell_cnt_q != '1) begin
          dwell_cnt_d = dwell_cnt_q + 1'b1;
        end
        at_goal = (dwell_cnt_d > dwell_q);
      end
    end else begin
      stop_armed_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_armed_q <= 1'b0;
      dwell_cnt_q  <= '0;
    end else if (s1_fire) begin
      stop_armed_q <= stop_armed_d;
      dwell_cnt_q  <= dwell_cnt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Per-axis gain and clamp
  // ---------------------------------------------------------------------------
  logic signed [VW-1:0] vx, vy, vw;

  bpvc_scale_clamp u_scale_x (
    .offset_i (signed'(x_q)),
    .gain_i   (gain_x_q),
    .limit_i  (max_lin_q),
    .vel_o    (vx)
  );

  bpvc_scale_clamp u_scale_y (
    .offset_i (signed'(y_q)),
    .gain_i   (gain_y_q),
    .limit_i  (max_lin_q),
    .vel_o    (vy)
  );

  bpvc_scale_clamp u_scale_yaw (
    .offset_i ($signed({{(OW - YW){yaw_q[YW-1]}}, yaw_q})),
    .gain_i   (gain_yaw_q),
    .limit_i  (max_ang_q),
    .vel_o    (vw)
  );

  // ---------------------------------------------------------------------------
  // Result register: velocities forced to zero inside the stop region
  // ---------------------------------------------------------------------------
  logic [VW-1:0] vel_x_q, vel_y_q, vel_yaw_q;
  logic          at_goal_q;

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      vel_x_q   <= in_stop ? '0 : vx;
      vel_y_q   <= in_stop ? '0 : vy;
      vel_yaw_q <= in_stop ? '0 : vw;
      at_goal_q <= at_goal;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {vel_yaw_q, vel_y_q, vel_x_q};
  assign m_axis_tuser  = at_goal_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // at-goal is only ever reported from inside the stop region
  a_goal_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && at_goal_q |-> (vel_x_q == '0) && (vel_y_q == '0) && (vel_yaw_q == '0))
    else $error("at-goal word carries non-zero velocity");

  // stop tracking moves only with a word leaving stage 1
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(stop_armed_q) && $stable(dwell_cnt_q))
    else $error("dwell state changed without a word");

  // dwell counter holds, steps by one or restarts from zero
  a_dwell_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> (dwell_cnt_q == $past(dwell_cnt_q))
             || (dwell_cnt_q == $past(dwell_cnt_q) + 1'b1)
             || (dwell_cnt_q == '0))
    else $error("dwell counter jumped");

  // a result appears only after a word sat in stage 1
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(s1_valid_q))
    else $error("result word without a source word");

endmodule

FILE: hdl/bpvc_scale_clamp.sv
// One axis of the controller: offset times Q8.8 gain, floored, clamped to +/-limit.
// Depends on bpvc_pkg for widths.
module bpvc_scale_clamp (
  input  logic signed [bpvc_pkg::OFFSET_W-1:0] offset_i,
  input  logic        [bpvc_pkg::GAIN_W-1:0]   gain_i,
  input  logic        [bpvc_pkg::LIMIT_W-1:0]  limit_i,
  output logic signed [bpvc_pkg::VEL_W-1:0]    vel_o
);

  localparam int PROD_W = bpvc_pkg::OFFSET_W + bpvc_pkg::GAIN_W + 1;
  localparam int QUOT_W = PROD_W - 8;

  logic signed [PROD_W-1:0] prod;
  logic signed [QUOT_W-1:0] quot;
  logic signed [QUOT_W-1:0] lim_pos;
  logic signed [QUOT_W-1:0] lim_neg;

  // gain is unsigned: zero bit on top keeps the product signed
  assign prod    = offset_i * $signed({1'b0, gain_i});
  // arithmetic shift by 8 = floor division by 256
  assign quot    = $signed(prod[PROD_W-1:8]);
  assign lim_pos = $signed({{(QUOT_W - bpvc_pkg::LIMIT_W){1'b0}}, limit_i});
  assign lim_neg = -lim_pos;

  always_comb begin
    priority if (quot > lim_pos) begin
      vel_o = lim_pos[bpvc_pkg::VEL_W-1:0];
    end else if (quot < lim_neg) begin
      vel_o = lim_neg[bpvc_pkg::VEL_W-1:0];
    end else begin
      vel_o = quot[bpvc_pkg::VEL_W-1:0];
    end
  end

endmodule
